/* src/tis_pkg.sv */
// ----------------------------------------------------------------------------
// tis_pkg
// Shared types, widths and codes of the timed irrigation sequencer.
// ----------------------------------------------------------------------------
package tis_pkg;

	localparam int MOIST_W   = 12;
	localparam int TIME_W    = 24;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 24;

	localparam int PAUSE_TICKS_DEF = 1000;
	localparam int COUNT_BITS_DEF  = 24;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DRY_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WATER_TIME    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FERT_TIME     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHECK_PERIOD  = 2'd3;

	// Register reset values
	localparam logic [MOIST_W-1:0] DRY_THRESHOLD_RST = 12'd2500;
	localparam logic [TIME_W-1:0]  WATER_TIME_RST    = 24'd5000;
	localparam logic [TIME_W-1:0]  FERT_TIME_RST     = 24'd3000;
	localparam logic [TIME_W-1:0]  CHECK_PERIOD_RST  = 24'd60000;

	// Phase codes as shown on the phase output
	localparam logic [1:0] PHASE_WAIT  = 2'd0;
	localparam logic [1:0] PHASE_WATER = 2'd1;
	localparam logic [1:0] PHASE_PAUSE = 2'd2;
	localparam logic [1:0] PHASE_FERT  = 2'd3;

	typedef enum logic [3:0] {
		PH_WAIT  = 4'b0001,
		PH_WATER = 4'b0010,
		PH_PAUSE = 4'b0100,
		PH_FERT  = 4'b1000
	} phase_t;

	function automatic logic [1:0] phase_code(input phase_t ph);
		logic [1:0] code;
		case (ph)
			PH_WAIT:  code = PHASE_WAIT;
			PH_WATER: code = PHASE_WATER;
			PH_PAUSE: code = PHASE_PAUSE;
			PH_FERT:  code = PHASE_FERT;
			default:  code = PHASE_WAIT;
		endcase
		return code;
	endfunction

endpackage

/* src/timed_irrigation_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_irrigation_sequencer
// Tick-driven water / pause / fertilizer pump sequencer with periodic checks.
// ----------------------------------------------------------------------------
// Usage:
//   Each input beat is one millisecond tick carrying the moisture sample,
//   the two tank-level bits and the mode flags. Each accepted tick yields
//   exactly one output beat: the pump run flags, the tank-empty alerts,
//   the current phase and the moisture value latched at the last check.
//   A tick accepted at one edge shows its result beat on the outputs from
//   the next cycle on. A new tick can be taken every cycle while in_ready is
//   high; in_ready stays high while the output register is empty or being
//   drained, so throughput is one beat per clock. The per-tick work is one
//   pass of compare, counter load/decrement and phase selection between the
//   state registers and the output register.
//   When the receiver stalls, the result beat holds in the output register
//   and in_ready drops until it is taken.
//   Reset puts the sequencer in the waiting phase with its counter at zero,
//   so the first tick makes a check; alerts and the latched sample clear and
//   the configuration registers take their default values.
//   Configuration writes are registered and are meant for idle periods.
// ----------------------------------------------------------------------------
module timed_irrigation_sequencer
	import tis_pkg::*;
#(
	parameter int PAUSE_TICKS = PAUSE_TICKS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// tick input
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [MOIST_W-1:0]    moisture,
	input  logic                  water_present,
	input  logic                  fert_present,
	input  logic                  auto_enable,
	input  logic                  water_manual,
	input  logic                  fert_manual,
	// result output
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  water_pump_on,
	output logic                  fert_pump_on,
	output logic                  water_alert,
	output logic                  fert_alert,
	output logic [1:0]            phase,
	output logic [MOIST_W-1:0]    moisture_seen
);

	// Largest counter value; 33 bits so that a 32-bit counter still fits.
	localparam logic [32:0] MAX_CNT   = (33'd1 << COUNT_BITS) - 33'd1;
	localparam logic [32:0] PAUSE_EXT = 33'(PAUSE_TICKS);
	localparam logic [COUNT_BITS-1:0] PAUSE_CNT = (PAUSE_EXT > MAX_CNT) ?
		MAX_CNT[COUNT_BITS-1:0] : PAUSE_EXT[COUNT_BITS-1:0];
	localparam bit PAUSE_NZ = (PAUSE_TICKS != 0);

	// Clamp a register time value to the counter range.
	function automatic logic [COUNT_BITS-1:0] sat_cnt(input logic [TIME_W-1:0] v);
		logic [32:0] ext;
		ext = 33'(v);
		return (ext > MAX_CNT) ? MAX_CNT[COUNT_BITS-1:0] : ext[COUNT_BITS-1:0];
	endfunction

	// Configuration registers
	logic [MOIST_W-1:0] dry_threshold_q;
	logic [TIME_W-1:0]  water_time_q;
	logic [TIME_W-1:0]  fert_time_q;
	logic [TIME_W-1:0]  check_period_q;

	// Sequencer state
	phase_t                phase_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  fert_ok_q;
	logic                  water_alert_q;
	logic                  fert_alert_q;
	logic [MOIST_W-1:0]    moisture_q;

	// Output register
	logic               out_valid_q;
	logic               water_pump_on_q;
	logic               fert_pump_on_q;
	logic               water_alert_out_q;
	logic               fert_alert_out_q;
	logic [1:0]         phase_out_q;
	logic [MOIST_W-1:0] moisture_seen_q;

	// Next-state signals
	phase_t                ph_end;
	logic [COUNT_BITS-1:0] cnt_end;
	phase_t                ph_chk;
	logic [COUNT_BITS-1:0] cnt_chk;
	logic [COUNT_BITS-1:0] cnt_nxt;
	logic                  fert_ok_nxt;
	logic                  water_alert_nxt;
	logic                  fert_alert_nxt;
	logic [MOIST_W-1:0]    moisture_nxt;
	logic                  irrigate;
	logic                  in_fire;

	logic [COUNT_BITS-1:0] wait_cnt;
	logic [COUNT_BITS-1:0] water_cnt;
	logic [COUNT_BITS-1:0] fert_cnt;
	logic                  water_nz;
	logic                  fert_nz;

	assign wait_cnt  = sat_cnt(check_period_q);
	assign water_cnt = sat_cnt(water_time_q);
	assign fert_cnt  = sat_cnt(fert_time_q);
	assign water_nz  = (water_time_q != '0);
	assign fert_nz   = (fert_time_q != '0);

	// Space in the output register: empty, or its beat leaves this cycle.
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;

	assign irrigate = auto_enable && !water_manual && !fert_manual &&
		(moisture > dry_threshold_q) && water_present;

	always_comb begin
		// First: a running phase whose counter ran out hands over; zero-length
		// phases fall through to the one after.
		ph_end  = phase_q;
		cnt_end = count_q;
		if (count_q == '0) begin
			case (phase_q)
				PH_WATER: begin
					if (PAUSE_NZ) begin
						ph_end  = PH_PAUSE;
						cnt_end = PAUSE_CNT;
					end else if (fert_ok_q && fert_nz) begin
						ph_end  = PH_FERT;
						cnt_end = fert_cnt;
					end else begin
						ph_end  = PH_WAIT;
						cnt_end = wait_cnt;
					end
				end
				PH_PAUSE: begin
					if (fert_ok_q && fert_nz) begin
						ph_end  = PH_FERT;
						cnt_end = fert_cnt;
					end else begin
						ph_end  = PH_WAIT;
						cnt_end = wait_cnt;
					end
				end
				PH_FERT: begin
					ph_end  = PH_WAIT;
					cnt_end = wait_cnt;
				end
				default: ;
			endcase
		end

		// Then: the check, when waiting with the counter run out.
		ph_chk          = ph_end;
		cnt_chk         = cnt_end;
		fert_ok_nxt     = fert_ok_q;
		water_alert_nxt = water_alert_q;
		fert_alert_nxt  = fert_alert_q;
		moisture_nxt    = moisture_q;
		if (ph_end == PH_WAIT && cnt_end == '0) begin
			moisture_nxt    = moisture;
			water_alert_nxt = !water_present;
			fert_alert_nxt  = !fert_present;
			if (irrigate) begin
				fert_ok_nxt = fert_present;
				if (water_nz) begin
					ph_chk  = PH_WATER;
					cnt_chk = water_cnt;
				end else if (PAUSE_NZ) begin
					ph_chk  = PH_PAUSE;
					cnt_chk = PAUSE_CNT;
				end else if (fert_present && fert_nz) begin
					ph_chk  = PH_FERT;
					cnt_chk = fert_cnt;
				end else begin
					ph_chk  = PH_WAIT;
					cnt_chk = wait_cnt;
				end
			end else begin
				ph_chk  = PH_WAIT;
				cnt_chk = wait_cnt;
			end
		end

		// Last: count down a nonzero counter.
		cnt_nxt = (cnt_chk != '0) ? cnt_chk - COUNT_BITS'(1) : cnt_chk;
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dry_threshold_q <= DRY_THRESHOLD_RST;
			water_time_q    <= WATER_TIME_RST;
			fert_time_q     <= FERT_TIME_RST;
			check_period_q  <= CHECK_PERIOD_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DRY_THRESHOLD: dry_threshold_q <= cfg_data[MOIST_W-1:0];
				REG_WATER_TIME:    water_time_q    <= cfg_data[TIME_W-1:0];
				REG_FERT_TIME:     fert_time_q     <= cfg_data[TIME_W-1:0];
				REG_CHECK_PERIOD:  check_period_q  <= cfg_data[TIME_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer state: advance once per accepted tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			count_q       <= '0;
			fert_ok_q     <= 1'b0;
			water_alert_q <= 1'b0;
			fert_alert_q  <= 1'b0;
			moisture_q    <= '0;
		end else if (in_fire) begin
			phase_q       <= ph_chk;
			count_q       <= cnt_nxt;
			fert_ok_q     <= fert_ok_nxt;
			water_alert_q <= water_alert_nxt;
			fert_alert_q  <= fert_alert_nxt;
			moisture_q    <= moisture_nxt;
		end
	end

	// Output register: load on accept, drop valid once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			water_pump_on_q   <= (ph_chk == PH_WATER);
			fert_pump_on_q    <= (ph_chk == PH_FERT);
			water_alert_out_q <= water_alert_nxt;
			fert_alert_out_q  <= fert_alert_nxt;
			phase_out_q       <= phase_code(ph_chk);
			moisture_seen_q   <= moisture_nxt;
		end
	end

	assign out_valid     = out_valid_q;
	assign water_pump_on = water_pump_on_q;
	assign fert_pump_on  = fert_pump_on_q;
	assign water_alert   = water_alert_out_q;
	assign fert_alert    = fert_alert_out_q;
	assign phase         = phase_out_q;
	assign moisture_seen = moisture_seen_q;

endmodule

/* src/tis_checker.sv */
// ----------------------------------------------------------------------------
// tis_checker
// Port-level checks of the timed irrigation sequencer, bound to its top level.
// ----------------------------------------------------------------------------
module tis_checker
	import tis_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               water_pump_on,
	input logic               fert_pump_on,
	input logic               water_alert,
	input logic               fert_alert,
	input logic [1:0]         phase,
	input logic [MOIST_W-1:0] moisture_seen
);

	// An accepted tick always shows up as a result beat next cycle.
	a_accept_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("accepted tick produced no result beat");

	// A held result blocks new ticks.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("tick taken while result beat stalled");

	// Pump flags agree with the reported phase.
	a_pumps_match_phase: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (water_pump_on == (phase == PHASE_WATER)) &&
			(fert_pump_on == (phase == PHASE_FERT)))
		else $error("pump flags disagree with phase");

	// A stalled result beat holds.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(phase) &&
			$stable(moisture_seen) && $stable(water_alert) && $stable(fert_alert))
		else $error("stalled result beat changed");

endmodule

bind timed_irrigation_sequencer tis_checker u_tis_checker (.*);

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed irrigation sequencer: a table of directed
// ticks, then random ticks over several register settings and flow-control
// mixes, each beat checked against its row's answer or a cycle-free model of the phases.
// ----------------------------------------------------------------------------
module tb
	import tis_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int PAUSE_LEN   = PAUSE_TICKS_DEF;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOW_MAX    = 10;

	// One tick as offered on the input channel
	typedef struct packed {
		logic [MOIST_W-1:0] moisture;
		logic               water_present;
		logic               fert_present;
		logic               auto_enable;
		logic               water_manual;
		logic               fert_manual;
	} tick_t;

	// One result beat as seen on the output channel
	typedef struct packed {
		logic               water_pump_on;
		logic               fert_pump_on;
		logic               water_alert;
		logic               fert_alert;
		logic [1:0]         phase;
		logic [MOIST_W-1:0] moisture_seen;
	} reading_t;

	typedef struct {
		tick_t    t;
		bit       typed;
		reading_t r;
	} directed_row_t;

	// Register setting and flow-control mix of one random stretch
	typedef struct {
		logic [CFG_DATA_W-1:0] dry;
		logic [CFG_DATA_W-1:0] water;
		logic [CFG_DATA_W-1:0] fert;
		logic [CFG_DATA_W-1:0] period;
		int                    send_idle;
		int                    recv_stall;
		int                    items;
		bit                    long_hold;
		bit                    drain_mid;
	} stretch_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = REG_DRY_THRESHOLD;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;
	logic                  in_valid      = 1'b0;
	logic                  in_ready;
	logic [MOIST_W-1:0]    moisture      = '0;
	logic                  water_present = 1'b0;
	logic                  fert_present  = 1'b0;
	logic                  auto_enable   = 1'b0;
	logic                  water_manual  = 1'b0;
	logic                  fert_manual   = 1'b0;
	logic                  out_valid;
	logic                  out_ready     = 1'b0;
	logic                  water_pump_on;
	logic                  fert_pump_on;
	logic                  water_alert;
	logic                  fert_alert;
	logic [1:0]            phase;
	logic [MOIST_W-1:0]    moisture_seen;

	timed_irrigation_sequencer u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.moisture      (moisture),
		.water_present (water_present),
		.fert_present  (fert_present),
		.auto_enable   (auto_enable),
		.water_manual  (water_manual),
		.fert_manual   (fert_manual),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.water_pump_on (water_pump_on),
		.fert_pump_on  (fert_pump_on),
		.water_alert   (water_alert),
		.fert_alert    (fert_alert),
		.phase         (phase),
		.moisture_seen (moisture_seen)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Sequencer model: register copies and state, at reset values
	// ------------------------------------------------------------------
	logic [MOIST_W-1:0] dry_thr_cfg  = DRY_THRESHOLD_RST;
	logic [TIME_W-1:0]  water_cfg    = WATER_TIME_RST;
	logic [TIME_W-1:0]  fert_cfg     = FERT_TIME_RST;
	logic [TIME_W-1:0]  period_cfg   = CHECK_PERIOD_RST;

	logic [1:0]         ph_model     = PHASE_WAIT;
	logic [TIME_W-1:0]  ticks_left   = '0;   // zero: first tick makes a check
	logic               fert_ok      = 1'b0;
	logic               w_alert      = 1'b0;
	logic               f_alert      = 1'b0;
	logic [MOIST_W-1:0] moist_held   = '0;

	reading_t expected_readings[$];
	int       mismatch_count = 0;
	int       send_idle_pct  = 0;
	int       recv_stall_pct = 0;
	int       hold_request   = 0;
	int       hold_left      = 0;
	int       cycle_count    = 0;

	// Phase lengths all fit in 24 bits here, so no saturation step is needed.
	function automatic void enter_wait();
		ph_model   = PHASE_WAIT;
		ticks_left = period_cfg;
	endfunction

	function automatic void enter_fert();
		if (fert_ok && fert_cfg != '0) begin
			ph_model   = PHASE_FERT;
			ticks_left = fert_cfg;
		end else begin
			enter_wait();
		end
	endfunction

	function automatic void enter_pause();
		if (PAUSE_LEN != 0) begin
			ph_model   = PHASE_PAUSE;
			ticks_left = TIME_W'(PAUSE_LEN);
		end else begin
			enter_fert();
		end
	endfunction

	// Advance the model by one tick and return the beat it shows
	function automatic reading_t predict_reading(input tick_t t);
		reading_t r;
		// end an expired running phase first; zero-length successors fall through
		if (ticks_left == '0) begin
			case (ph_model)
				PHASE_WATER: enter_pause();
				PHASE_PAUSE: enter_fert();
				PHASE_FERT:  enter_wait();
				default: ;
			endcase
		end
		// check: latch sample and alerts, then decide whether to irrigate
		if (ph_model == PHASE_WAIT && ticks_left == '0) begin
			moist_held = t.moisture;
			w_alert    = !t.water_present;
			f_alert    = !t.fert_present;
			if (t.auto_enable && !t.water_manual && !t.fert_manual &&
					t.moisture > dry_thr_cfg && t.water_present) begin
				fert_ok = t.fert_present;
				if (water_cfg != '0) begin
					ph_model   = PHASE_WATER;
					ticks_left = water_cfg;
				end else begin
					enter_pause();
				end
			end else begin
				enter_wait();
			end
		end
		r.water_pump_on = (ph_model == PHASE_WATER);
		r.fert_pump_on  = (ph_model == PHASE_FERT);
		r.water_alert   = w_alert;
		r.fert_alert    = f_alert;
		r.phase         = ph_model;
		r.moisture_seen = moist_held;
		if (ticks_left != '0)
			ticks_left = ticks_left - 1'b1;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// Write one register; the caller drops cfg_we after the last write so
	// back-to-back writes never lower and raise it within one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		case (idx)
			REG_DRY_THRESHOLD: dry_thr_cfg = data[MOIST_W-1:0];
			REG_WATER_TIME:    water_cfg   = data;
			REG_FERT_TIME:     fert_cfg    = data;
			REG_CHECK_PERIOD:  period_cfg  = data;
			default: ;
		endcase
	endtask

	// Offer one tick beat, hold it until taken, then log its expected result.
	// Entered and left right after a rising edge.
	task automatic send_tick(input tick_t t, input bit typed, input reading_t typed_r);
		reading_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		moisture      <= t.moisture;
		water_present <= t.water_present;
		fert_present  <= t.fert_present;
		auto_enable   <= t.auto_enable;
		water_manual  <= t.water_manual;
		fert_manual   <= t.fert_manual;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		// keep the model running even where the row carries its own answer
		want = predict_reading(t);
		expected_readings.push_back(typed ? typed_r : want);
	endtask

	// Drop valid and wait until every beat is back, plus the output latency
	task automatic drain();
		in_valid <= 1'b0;
		while (expected_readings.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Random ticks, with the moisture
	// often parked on the threshold edge
	function automatic tick_t random_tick();
		tick_t t;
		case ($urandom_range(7))
			0:       t.moisture = '0;
			1:       t.moisture = '1;
			2:       t.moisture = dry_thr_cfg;
			3:       t.moisture = (dry_thr_cfg == '1) ? dry_thr_cfg : dry_thr_cfg + 1'b1;
			default: t.moisture = MOIST_W'($urandom_range(4095));
		endcase
		t.water_present = ($urandom_range(99) < 85);
		t.fert_present  = ($urandom_range(99) < 75);
		t.auto_enable   = ($urandom_range(99) < 85);
		t.water_manual  = ($urandom_range(99) < 10);
		t.fert_manual   = ($urandom_range(99) < 10);
		return t;
	endfunction

	// ------------------------------------------------------------------
	// Receiver and checker: take beats, compare with the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		reading_t got;
		reading_t want;
		if (out_valid === 1'b1 && out_ready) begin
			got = '{water_pump_on, fert_pump_on, water_alert, fert_alert, phase, moisture_seen};
			if (expected_readings.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= SHOW_MAX)
					$display("%0t: result beat with nothing expected: %p", $realtime, got);
			end else begin
				want = expected_readings.pop_front();
				if (got.water_pump_on !== want.water_pump_on ||
						got.fert_pump_on !== want.fert_pump_on ||
						got.water_alert !== want.water_alert ||
						got.fert_alert !== want.fert_alert ||
						got.phase !== want.phase ||
						got.moisture_seen !== want.moisture_seen) begin
					mismatch_count++;
					if (mismatch_count <= SHOW_MAX)
						$display("%0t: mismatch\n  expected %p\n  actual   %p",
							$realtime, want, got);
				end
			end
		end
		// a long hold-off, counted here, lets the block back up and stall its input
		if (hold_request != 0) begin
			hold_left    = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------

	// With a zero check period every idle tick is a check, so the rows up to
	// the first irrigating one can be read straight off the condition.
	directed_row_t directed_rows[] = '{
		// moisture on the default threshold: not dry
		'{'{12'd2500, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b0, 1'b0, PHASE_WAIT, 12'd2500}},
		// automatic mode off
		'{'{12'd4095, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b0, 1'b0, PHASE_WAIT, 12'd4095}},
		// water pump manual, fertilizer tank empty
		'{'{12'd4095, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b0, 1'b1, PHASE_WAIT, 12'd4095}},
		// fertilizer pump manual
		'{'{12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b1,
			'{1'b0, 1'b0, 1'b0, 1'b0, PHASE_WAIT, 12'd4095}},
		// water tank empty blocks irrigation
		'{'{12'd4095, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b1, 1'b0, PHASE_WAIT, 12'd4095}},
		// both tanks empty, wettest reading
		'{'{12'd0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b0, 1'b0, 1'b1, 1'b1, PHASE_WAIT, 12'd0}},
		// just above threshold: water phase starts on this tick
		'{'{12'd2501, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b1,
			'{1'b1, 1'b0, 1'b0, 1'b0, PHASE_WATER, 12'd2501}},
		// rest of the water phase and into the pause; inputs ignored meanwhile
		'{'{12'd0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
		'{'{12'd4095, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
		'{'{12'd1234, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
		'{'{12'd3000, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
		'{'{12'd2048, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}, 1'b0, '0}
	};

	stretch_t stretches[] = '{
		// no idling; long receiver hold-off while ticks keep coming
		'{24'd2000, 24'd5, 24'd4, 24'd0, 0, 0, 150, 1'b1, 1'b0},
		// zero threshold, water phase skipped, sender idling
		'{24'd0, 24'd0, 24'd3, 24'd2, 83, 0, 100, 1'b0, 1'b0},
		// fertilizer phase skipped, receiver stalling
		'{24'd1000, 24'd7, 24'd0, 24'd1, 0, 83, 100, 1'b0, 1'b0},
		// top threshold written with junk above bit 11: never dry
		'{24'hFFFFFF, 24'd2, 24'd2, 24'd3, 34, 34, 60, 1'b0, 1'b0},
		// short phases; sender waits for all results midway
		'{24'd500, 24'd1, 24'd1, 24'd0, 0, 0, 170, 1'b0, 1'b1},
		// longest phases and wait
		'{24'd0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 34, 34, 100, 1'b0, 1'b0}
	};

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		// leave the threshold at reset; shorten the timers so checks come fast
		write_reg(REG_WATER_TIME, 24'd3);
		write_reg(REG_FERT_TIME, 24'd2);
		write_reg(REG_CHECK_PERIOD, 24'd0);
		cfg_we <= 1'b0;

		foreach (directed_rows[i])
			send_tick(directed_rows[i].t, directed_rows[i].typed, directed_rows[i].r);
		drain();

		// the sequence state carries across stretches; only registers change
		foreach (stretches[s]) begin
			write_reg(REG_DRY_THRESHOLD, stretches[s].dry);
			write_reg(REG_WATER_TIME, stretches[s].water);
			write_reg(REG_FERT_TIME, stretches[s].fert);
			write_reg(REG_CHECK_PERIOD, stretches[s].period);
			cfg_we <= 1'b0;
			send_idle_pct  = stretches[s].send_idle;
			recv_stall_pct = stretches[s].recv_stall;
			if (stretches[s].long_hold)
				hold_request = 200;
			for (int n = 0; n < stretches[s].items; n++) begin
				send_tick(random_tick(), 1'b0, '0);
				if (stretches[s].drain_mid && n == stretches[s].items / 2)
					drain();
			end
			drain();
		end

		if (mismatch_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
